@@ hdl/cleb_pkg.sv @@
package cleb_pkg;

  localparam int LINE_DEPTH_DEF = 64;

  localparam int ACT_W  = 3;
  localparam int CHAR_W = 8;
  localparam int CNT_W  = 7;
  localparam int POS_W  = 6;

  localparam logic [CNT_W-1:0] MAX_LEN_RST = 7'd64;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT    = 3'd0,
    ACT_BACKSPACE = 3'd1,
    ACT_FORWARD   = 3'd2,
    ACT_BACKWARD  = 3'd3,
    ACT_CLEAR     = 3'd4,
    ACT_READ      = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_CLEAR,
    CELL_LOAD,
    CELL_SHIFT
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } ctrl_state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t          op;
    logic [CNT_W-1:0]  cursor;
    logic [CNT_W-1:0]  length;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
  } cell_cmd_t;

endpackage

@@ hdl/cleb_cell.sv @@
module cleb_cell #(
  parameter int INDEX = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cleb_pkg::cell_cmd_t         cmd,
  input  logic [cleb_pkg::CHAR_W-1:0] left_data,
  input  logic [cleb_pkg::CHAR_W-1:0] right_data,
  input  logic [cleb_pkg::CHAR_W-1:0] right_carry,
  output logic [cleb_pkg::CHAR_W-1:0] data,
  output logic [cleb_pkg::CHAR_W-1:0] carry
);

  localparam logic [31:0] IDX  = 32'(INDEX);
  localparam logic [31:0] IDX1 = 32'(INDEX + 1);

  logic [cleb_pkg::CHAR_W-1:0] data_r, data_nxt;
  logic [cleb_pkg::CHAR_W-1:0] carry_r, carry_nxt;

  always_comb begin
    data_nxt  = data_r;
    carry_nxt = carry_r;
    case (cmd.op)
      cleb_pkg::CELL_INSERT: begin
        if (IDX == 32'(cmd.cursor)) begin
          data_nxt = cmd.ch;
        end else if (IDX > 32'(cmd.cursor) && IDX <= 32'(cmd.length)) begin
          data_nxt = left_data;
        end
      end
      cleb_pkg::CELL_DELETE: begin
        // vacated slot just past the new end is zeroed
        if (IDX1 == 32'(cmd.length)) begin
          data_nxt = '0;
        end else if (IDX1 >= 32'(cmd.cursor) && IDX1 < 32'(cmd.length)) begin
          data_nxt = right_data;
        end
      end
      cleb_pkg::CELL_CLEAR: begin
        data_nxt = '0;
      end
      cleb_pkg::CELL_LOAD: begin
        carry_nxt = (IDX == 32'(cmd.pos)) ? data_r : '0;
      end
      cleb_pkg::CELL_SHIFT: begin
        carry_nxt = right_carry;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
  end

  assign data  = data_r;
  assign carry = carry_r;

endmodule

@@ hdl/cleb_ctrl.sv @@
module cleb_ctrl #(
  parameter int LINE_DEPTH = cleb_pkg::LINE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cleb_pkg::ACT_W-1:0]  in_action,
  input  logic [cleb_pkg::CHAR_W-1:0] in_character,
  input  logic [cleb_pkg::CNT_W-1:0]  in_count,
  input  logic [cleb_pkg::POS_W-1:0]  in_position,
  input  logic                        cfg_wr_en,
  input  logic [cleb_pkg::CNT_W-1:0]  cfg_wr_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cleb_pkg::CNT_W-1:0]  out_cursor_pos,
  output logic [cleb_pkg::CNT_W-1:0]  out_line_length,
  output logic                        out_applied,
  output logic [cleb_pkg::CHAR_W-1:0] out_read_char,
  output logic                        out_at_start,
  output logic                        out_at_end,
  output logic                        out_is_empty,
  output logic                        out_is_full,
  output cleb_pkg::cell_cmd_t         cell_cmd,
  input  logic [cleb_pkg::CHAR_W-1:0] carry_head
);

  cleb_pkg::ctrl_state_t state_r, state_nxt;

  logic [cleb_pkg::CNT_W-1:0]  cursor_r, cursor_nxt;
  logic [cleb_pkg::CNT_W-1:0]  length_r, length_nxt;
  logic [cleb_pkg::CNT_W-1:0]  max_len_r;
  logic [cleb_pkg::POS_W-1:0]  cnt_r, cnt_nxt;
  logic                        rd_ok_r, rd_ok_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [cleb_pkg::CNT_W-1:0]  out_cursor_r, out_length_r;
  logic                        out_applied_r, applied_nxt;
  logic [cleb_pkg::CHAR_W-1:0] out_char_r, char_nxt;
  logic                        out_start_r, out_end_r, out_empty_r, out_full_r;
  logic                        out_load;
  logic                        accept;
  logic [cleb_pkg::CNT_W-1:0]  limit;
  logic [cleb_pkg::CNT_W-1:0]  gap;

  // usable limit: register capped at the store depth
  assign limit = (32'(max_len_r) > 32'(LINE_DEPTH)) ? cleb_pkg::CNT_W'(LINE_DEPTH)
                                                   : max_len_r;
  assign gap = length_r - cursor_r;

  assign in_stall = !(state_r == cleb_pkg::ST_IDLE && (!out_valid_r || !out_stall));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    length_nxt    = length_r;
    cnt_nxt       = cnt_r;
    rd_ok_nxt     = rd_ok_r;
    applied_nxt   = 1'b0;
    char_nxt      = '0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    cell_cmd.op     = cleb_pkg::CELL_HOLD;
    cell_cmd.cursor = cursor_r;
    cell_cmd.length = length_r;
    cell_cmd.pos    = in_position;
    cell_cmd.ch     = in_character;
    case (state_r)
      cleb_pkg::ST_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          case (cleb_pkg::action_t'(in_action))
            cleb_pkg::ACT_INSERT: begin
              if (length_r < limit) begin
                cell_cmd.op = cleb_pkg::CELL_INSERT;
                cursor_nxt  = cursor_r + 1'b1;
                length_nxt  = length_r + 1'b1;
                applied_nxt = 1'b1;
              end
            end
            cleb_pkg::ACT_BACKSPACE: begin
              if (cursor_r != '0) begin
                cell_cmd.op = cleb_pkg::CELL_DELETE;
                cursor_nxt  = cursor_r - 1'b1;
                length_nxt  = length_r - 1'b1;
                applied_nxt = 1'b1;
              end
            end
            cleb_pkg::ACT_FORWARD: begin
              cursor_nxt = (in_count > gap) ? length_r : cursor_r + in_count;
            end
            cleb_pkg::ACT_BACKWARD: begin
              cursor_nxt = (cursor_r < in_count) ? '0 : cursor_r - in_count;
            end
            cleb_pkg::ACT_CLEAR: begin
              cell_cmd.op = cleb_pkg::CELL_CLEAR;
              cursor_nxt  = '0;
              length_nxt  = '0;
            end
            cleb_pkg::ACT_READ: begin
              // latch the addressed byte, then walk it down to cell 0
              cell_cmd.op = cleb_pkg::CELL_LOAD;
              out_load    = 1'b0;
              cnt_nxt     = in_position;
              rd_ok_nxt   = {1'b0, in_position} < length_r;
              state_nxt   = cleb_pkg::ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      cleb_pkg::ST_READ: begin
        if (cnt_r == '0) begin
          out_load  = 1'b1;
          char_nxt  = rd_ok_r ? carry_head : '0;
          state_nxt = cleb_pkg::ST_IDLE;
        end else begin
          cell_cmd.op = cleb_pkg::CELL_SHIFT;
          cnt_nxt     = cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = cleb_pkg::ST_IDLE;
      end
    endcase
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cleb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      length_r    <= '0;
      max_len_r   <= cleb_pkg::MAX_LEN_RST;
      out_valid_r <= 1'b0;
    end else begin
      cursor_r    <= cursor_nxt;
      length_r    <= length_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    rd_ok_r <= rd_ok_nxt;
    if (out_load) begin
      out_cursor_r  <= cursor_nxt;
      out_length_r  <= length_nxt;
      out_applied_r <= applied_nxt;
      out_char_r    <= char_nxt;
      out_start_r   <= (cursor_nxt == '0);
      out_end_r     <= (cursor_nxt == length_nxt);
      out_empty_r   <= (length_nxt == '0);
      out_full_r    <= (length_nxt >= limit);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cursor_pos  = out_cursor_r;
  assign out_line_length = out_length_r;
  assign out_applied     = out_applied_r;
  assign out_read_char   = out_char_r;
  assign out_at_start    = out_start_r;
  assign out_at_end      = out_end_r;
  assign out_is_empty    = out_empty_r;
  assign out_is_full     = out_full_r;

endmodule

@@ hdl/cursor_line_edit_buffer.sv @@
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  in_action, in_character, in_count, in_position
// out       output     out_valid / out_stall  cursor, length, applied, read char, flags
// cfg       input      cfg_wr_en            cfg_wr_data (max_length)
//
// insert, backspace, forward, backward, clear and unused actions are applied directly:
// every cell updates from its neighbors at the accepting edge
// read latches the addressed byte, which then walks down the carry chain
// one cell per cycle to cell 0
// synchronous active-low reset empties the line, zeroes the store, limit back to 64
// a transaction is taken only while the controller is idle and the result register
// is empty or being drained in the same cycle
module cursor_line_edit_buffer #(
  parameter int LINE_DEPTH = cleb_pkg::LINE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cleb_pkg::ACT_W-1:0]  in_action,
  input  logic [cleb_pkg::CHAR_W-1:0] in_character,
  input  logic [cleb_pkg::CNT_W-1:0]  in_count,
  input  logic [cleb_pkg::POS_W-1:0]  in_position,
  input  logic                        cfg_wr_en,
  input  logic [cleb_pkg::CNT_W-1:0]  cfg_wr_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cleb_pkg::CNT_W-1:0]  out_cursor_pos,
  output logic [cleb_pkg::CNT_W-1:0]  out_line_length,
  output logic                        out_applied,
  output logic [cleb_pkg::CHAR_W-1:0] out_read_char,
  output logic                        out_at_start,
  output logic                        out_at_end,
  output logic                        out_is_empty,
  output logic                        out_is_full
);

  // command broadcast to the whole row of cells
  cleb_pkg::cell_cmd_t cell_cmd;

  // per-cell stored byte and read carry
  logic [cleb_pkg::CHAR_W-1:0] cell_data  [LINE_DEPTH];
  logic [cleb_pkg::CHAR_W-1:0] cell_carry [LINE_DEPTH];

  // controller: cursor, length, limit register, read sequencing, result register
  cleb_ctrl #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_character    (in_character),
    .in_count        (in_count),
    .in_position     (in_position),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cursor_pos  (out_cursor_pos),
    .out_line_length (out_line_length),
    .out_applied     (out_applied),
    .out_read_char   (out_read_char),
    .out_at_start    (out_at_start),
    .out_at_end      (out_at_end),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full),
    .cell_cmd        (cell_cmd),
    .carry_head      (cell_carry[0])
  );

  // row of cells: insert pulls from the left neighbor, backspace from the right,
  // the read carry moves right to left toward cell 0
  for (genvar g = 0; g < LINE_DEPTH; g++) begin : g_cell
    logic [cleb_pkg::CHAR_W-1:0] left_data;
    logic [cleb_pkg::CHAR_W-1:0] right_data;
    logic [cleb_pkg::CHAR_W-1:0] right_carry;

    if (g == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_inner_l
      assign left_data = cell_data[g-1];
    end

    if (g == LINE_DEPTH - 1) begin : g_last
      assign right_data  = '0;
      assign right_carry = '0;
    end else begin : g_inner_r
      assign right_data  = cell_data[g+1];
      assign right_carry = cell_carry[g+1];
    end

    cleb_cell #(
      .INDEX (g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cell_cmd),
      .left_data   (left_data),
      .right_data  (right_data),
      .right_carry (right_carry),
      .data        (cell_data[g]),
      .carry       (cell_carry[g])
    );
  end

`ifndef SYNTH
  // cursor never runs past the end of the line
  a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cursor_pos <= out_line_length)
    else $error("cursor beyond line length");

  // an edit that changed the line never returns a read byte
  a_edit_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_applied |-> out_read_char == '0)
    else $error("read byte on an applied edit");

  // empty line implies cursor at start and at end
  a_empty_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_at_start && out_at_end)
    else $error("empty line with cursor off origin");

  // a read transaction holds off the next one while the carry walks
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == cleb_pkg::ACT_READ |=> in_stall)
    else $error("input taken during read walk");
`endif

endmodule
